### hw/rtl/twms_pkg.sv
// Shared types and codes for the timing wheel message scheduler.
// Used by twms_cell and timing_wheel_message_scheduler; no dependencies.
`timescale 1ns / 1ps

package twms_pkg;

  localparam int TIME_W   = 48;
  localparam int HANDLE_W = 16;

  typedef enum logic [2:0] {
    ST_STARTED    = 3'd0,
    ST_ACCEPTED   = 3'd1,
    ST_NOW        = 3'd2,
    ST_NOCLOCK    = 3'd3,
    ST_FULL       = 3'd4,
    ST_DISPATCHED = 3'd5
  } status_t;

  typedef struct packed {
    logic                valid;
    logic [TIME_W-1:0]   due;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // one operation at a time is broadcast along the chain
  typedef struct packed {
    logic clear;
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

### hw/rtl/twms_cell.sv
// One cell of the sorted entry chain: holds a single timed handle.
// Depends on twms_pkg for entry_t and cell_ctl_t.
`timescale 1ns / 1ps

module twms_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  twms_pkg::cell_ctl_t           ctl,
  input  logic [twms_pkg::TIME_W-1:0]   key_time,
  input  logic [twms_pkg::HANDLE_W-1:0] key_handle,
  input  logic                          left_gt,
  input  twms_pkg::entry_t              left_data,
  input  twms_pkg::entry_t              right_data,
  output logic                          gt,
  output twms_pkg::entry_t              data
);

  logic                          valid;
  logic [twms_pkg::TIME_W-1:0]   due;
  logic [twms_pkg::HANDLE_W-1:0] handle;

  // empty cells count as later than any key
  assign gt = !(valid && (due <= key_time));

  assign data.valid  = valid;
  assign data.due    = due;
  assign data.handle = handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.insert && gt) begin
      // cells behind the insertion point take their neighbor's valid bit
      valid <= left_gt ? left_data.valid : 1'b1;
    end else if (ctl.remove) begin
      valid <= right_data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear && ctl.insert && gt) begin
      if (left_gt) begin
        // make room: take the neighbor that moves right
        due    <= left_data.due;
        handle <= left_data.handle;
      end else begin
        due    <= key_time;
        handle <= key_handle;
      end
    end else if (!ctl.clear && ctl.remove) begin
      due    <= right_data.due;
      handle <= right_data.handle;
    end
  end

endmodule

### hw/rtl/timing_wheel_message_scheduler.sv
// Timing wheel message scheduler: top level with control and output register.
// Depends on twms_pkg and twms_cell.
// Latency: a result is registered on the edge after the item transfer, later under stalls.
// Items: one at a time, in_ready low until done; the unused mode and a poll with nothing due
// give no result; a poll with due entries makes one chain shift per transfer.
// Reset: all cells empty, current time zero, clock_valid clear; no clearing pass.
`timescale 1ns / 1ps

module timing_wheel_message_scheduler #(
  parameter int POOL_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [twms_pkg::TIME_W-1:0]   time_ticks,
  input  logic [twms_pkg::HANDLE_W-1:0] handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [twms_pkg::HANDLE_W-1:0] out_handle,
  output logic [twms_pkg::TIME_W-1:0]   out_time,
  output logic                          last
);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_SCHED = 2'd1;
  localparam logic [1:0] MODE_POLL  = 2'd2;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                        state;
  logic [1:0]                    item_mode;
  logic [twms_pkg::TIME_W-1:0]   item_time;
  logic [twms_pkg::HANDLE_W-1:0] item_handle;
  logic [twms_pkg::TIME_W-1:0]   current_time;
  logic                          clock_valid;
  twms_pkg::status_t             status_r;

  twms_pkg::entry_t    cells      [POOL_ENTRIES];
  twms_pkg::entry_t    left_data  [POOL_ENTRIES];
  twms_pkg::entry_t    right_data [POOL_ENTRIES];
  logic                gt         [POOL_ENTRIES];
  logic                left_gt    [POOL_ENTRIES];
  twms_pkg::cell_ctl_t ctl;

  logic              out_free;
  logic              head_due;
  logic              sched_now;
  logic              pool_full;
  twms_pkg::status_t sched_status;
  logic              exec;
  logic              result_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign status    = status_r;

  assign exec      = (state == S_EXEC);
  assign out_free  = !out_valid || out_ready;
  assign head_due  = !gt[0];
  assign pool_full = cells[POOL_ENTRIES-1].valid;
  assign sched_now = (item_time == '0) || (item_time < current_time);

  assign result_load = exec && out_free &&
                       ((item_mode == MODE_START) || (item_mode == MODE_SCHED) ||
                        ((item_mode == MODE_POLL) && head_due));

  always_comb begin
    priority if (sched_now) begin
      sched_status = twms_pkg::ST_NOW;
    end else if (!clock_valid) begin
      sched_status = twms_pkg::ST_NOCLOCK;
    end else if (pool_full) begin
      sched_status = twms_pkg::ST_FULL;
    end else begin
      sched_status = twms_pkg::ST_ACCEPTED;
    end
  end

  always_comb begin
    ctl.clear  = exec && (item_mode == MODE_START) && out_free;
    ctl.insert = exec && (item_mode == MODE_SCHED) && out_free
                 && (sched_status == twms_pkg::ST_ACCEPTED);
    ctl.remove = exec && (item_mode == MODE_POLL) && out_free && head_due;
  end

  for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_chain
    if (i == 0) begin : g_first
      assign left_gt[i]   = 1'b0;
      assign left_data[i] = '0;
    end else begin : g_mid
      assign left_gt[i]   = gt[i-1];
      assign left_data[i] = cells[i-1];
    end
    if (i == POOL_ENTRIES - 1) begin : g_end
      assign right_data[i] = '0;
    end else begin : g_rest
      assign right_data[i] = cells[i+1];
    end

    twms_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key_time   (item_time),
      .key_handle (item_handle),
      .left_gt    (left_gt[i]),
      .left_data  (left_data[i]),
      .right_data (right_data[i]),
      .gt         (gt[i]),
      .data       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      current_time <= '0;
      clock_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        clock_valid <= cfg_data;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_mode   <= mode;
            item_time   <= time_ticks;
            item_handle <= handle;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (item_mode)
            MODE_START: begin
              if (out_free) begin
                status_r     <= twms_pkg::ST_STARTED;
                out_handle   <= '0;
                out_time     <= '0;
                last         <= 1'b1;
                current_time <= item_time;
                state        <= S_IDLE;
              end
            end
            MODE_SCHED: begin
              if (out_free) begin
                status_r   <= sched_status;
                out_handle <= sched_now ? item_handle : '0;
                out_time   <= '0;
                last       <= 1'b1;
                state      <= S_IDLE;
              end
            end
            MODE_POLL: begin
              if (!head_due) begin
                current_time <= item_time;
                state        <= S_IDLE;
              end else if (out_free) begin
                status_r   <= twms_pkg::ST_DISPATCHED;
                out_handle <= cells[0].handle;
                out_time   <= cells[0].due;
                // final transfer when the next cell is not due
                last       <= gt[1];
                if (gt[1]) begin
                  current_time <= item_time;
                  state        <= S_IDLE;
                end
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
      endcase
    end
  end

  a_ctl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.clear, ctl.insert, ctl.remove}))
    else $error("more than one chain operation at once");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |-> !cells[POOL_ENTRIES-1].valid)
    else $error("insert into a full chain");

  a_remove_due: assert property (@(posedge clk) disable iff (rst)
    ctl.remove |-> (cells[0].valid && (cells[0].due <= item_time)))
    else $error("dispatch of an entry that is not due");

  for (genvar j = 1; j < POOL_ENTRIES; j++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cells[j].valid |-> (cells[j-1].valid && (cells[j-1].due <= cells[j].due)))
      else $error("cell chain out of order or not packed");
  end

endmodule
